[design/pva_pkg.sv]
// shared types and constants for the priority voice allocator
// no dependencies

package pva_pkg;

   localparam logic FUNC_PLAY = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [2:0] ACT_REJECT   = 3'd0;
   localparam logic [2:0] ACT_ASSIGN   = 3'd1;
   localparam logic [2:0] ACT_DROP     = 3'd2;
   localparam logic [2:0] ACT_START    = 3'd3;
   localparam logic [2:0] ACT_TIMEOUT  = 3'd4;
   localparam logic [2:0] ACT_RELEASE  = 3'd5;
   localparam logic [2:0] ACT_NO_CHG   = 3'd6;

   localparam logic [7:0] HOLD_SCALE_RESET = 8'd6;

   typedef struct packed {
      logic       func;
      logic [7:0] sound_id;
      logic [7:0] sound_priority;
      logic [7:0] hold_units;
      logic [3:0] channel_busy;
   } req_word_type;

   typedef struct packed {
      logic [1:0] slot;
      logic [2:0] action;
      logic [7:0] out_sound;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic play_step;
      logic play_commit;
      logic tick_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_slot;
   } dp_status_type;

endpackage

[design/priority_voice_allocator_top.sv]
// top level of the priority voice allocator: sequencer plus slot datapath
// depends on pva_pkg, pva_ctrl, pva_datapath
//
//   channel   ports                         direction   handshake
//   request   start, busy, req_word         in          start while busy low
//   result    rsp_valid, rsp_word           out         valid per result
//   csr       csr_wr_en, csr_wr_data        in          write on enable
//
// a play word scans one slot per cycle, then decides in a commit state;
// busy covers the scan and the commit, and the result is registered there.
// a tick word handles one slot per cycle through the shared hold compare:
// busy while it walks the slots, one result per slot on consecutive cycles.
// the result register is separate, so a new word is taken while the last
// result is on the port. reset is synchronous; the hold scale returns to 6.

module priority_voice_allocator_top #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pva_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output pva_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data
);

   pva_pkg::ctrl_cmd_type  cmd;
   pva_pkg::dp_status_type status;

   pva_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_word.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   pva_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

   // an accepted word always occupies the sequencer on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // play outcomes are always the only result of their word
   a_play_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.action == pva_pkg::ACT_REJECT ||
                    rsp_word.action == pva_pkg::ACT_ASSIGN ||
                    rsp_word.action == pva_pkg::ACT_DROP) |-> rsp_word.last)
      else $error("play result without last");

   // only a start or an assignment carries a sound number
   a_sound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.action != pva_pkg::ACT_START &&
      rsp_word.action != pva_pkg::ACT_ASSIGN |-> rsp_word.out_sound == 8'd0)
      else $error("unexpected sound number on result");

   // the final result of a word leaves the sequencer idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |-> !busy)
      else $error("sequencer still busy after final result");

endmodule

[design/pva_ctrl.sv]
// sequencer for the voice allocator: walks the slots for a play or a tick
// depends on pva_pkg

module pva_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_func,
   input  pva_pkg::dp_status_type status,
   output pva_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_PLAY_SCAN = 2'd1;
   localparam logic [1:0] ST_PLAY_DONE = 2'd2;
   localparam logic [1:0] ST_TICK      = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_func == pva_pkg::FUNC_TICK) ? ST_TICK : ST_PLAY_SCAN;
            end
         end
         ST_PLAY_SCAN: begin
            cmd.play_step = 1'b1;
            if (status.last_slot) state_in = ST_PLAY_DONE;
         end
         ST_PLAY_DONE: begin
            cmd.play_commit = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            cmd.tick_step = 1'b1;
            if (status.last_slot) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[design/pva_datapath.sv]
// slot table, scan registers and result register of the voice allocator
// depends on pva_pkg

module pva_datapath #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pva_pkg::ctrl_cmd_type  cmd,
   input  pva_pkg::req_word_type  req_word,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   output pva_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output pva_pkg::rsp_word_type  rsp_word
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [7:0]  slot_sound_ff    [NUM_SLOTS];
   logic [7:0]  slot_sound_in    [NUM_SLOTS];
   logic [7:0]  slot_priority_ff [NUM_SLOTS];
   logic [7:0]  slot_priority_in [NUM_SLOTS];
   logic [7:0]  slot_hold_ff     [NUM_SLOTS];
   logic [7:0]  slot_hold_in     [NUM_SLOTS];
   logic [15:0] slot_ticks_ff    [NUM_SLOTS];
   logic [15:0] slot_ticks_in    [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_active_ff, slot_active_in;
   logic [NUM_SLOTS-1:0] slot_pending_ff, slot_pending_in;

   pva_pkg::req_word_type req_ff, req_in;
   logic [7:0]       scale_ff, scale_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // first hit of each play category during the scan
   logic             dup_hit_ff, dup_hit_in, free_hit_ff, free_hit_in;
   logic             steal_hit_ff, steal_hit_in, repl_hit_ff, repl_hit_in;
   logic [IDX_W-1:0] dup_idx_ff, dup_idx_in, free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] steal_idx_ff, steal_idx_in, repl_idx_ff, repl_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   pva_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic        last_slot;
   logic [4:0]  idx_wide;
   logic        cur_busy;
   logic        cur_active, cur_pending;
   logic [7:0]  cur_sound, cur_priority, cur_hold;
   logic [15:0] cur_ticks, hold_limit;
   logic        wr_en;
   logic [IDX_W-1:0] wr_idx;

   assign last_slot        = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign status.last_slot = last_slot;

   // slots past the fourth have no busy bit
   assign idx_wide     = 5'(idx_ff);
   assign cur_busy     = (idx_wide < 5'd4) && req_ff.channel_busy[idx_wide[1:0]];
   assign cur_active   = slot_active_ff[idx_ff];
   assign cur_pending  = slot_pending_ff[idx_ff];
   assign cur_sound    = slot_sound_ff[idx_ff];
   assign cur_priority = slot_priority_ff[idx_ff];
   assign cur_hold     = slot_hold_ff[idx_ff];
   assign cur_ticks    = slot_ticks_ff[idx_ff];
   assign hold_limit   = 16'(cur_hold) * 16'(scale_ff);

   always_comb begin
      slot_sound_in    = slot_sound_ff;
      slot_priority_in = slot_priority_ff;
      slot_hold_in     = slot_hold_ff;
      slot_ticks_in    = slot_ticks_ff;
      slot_active_in   = slot_active_ff;
      slot_pending_in  = slot_pending_ff;
      req_in           = req_ff;
      scale_in         = csr_wr_en ? csr_wr_data : scale_ff;
      idx_in           = idx_ff;
      dup_hit_in       = dup_hit_ff;
      dup_idx_in       = dup_idx_ff;
      free_hit_in      = free_hit_ff;
      free_idx_in      = free_idx_ff;
      steal_hit_in     = steal_hit_ff;
      steal_idx_in     = steal_idx_ff;
      repl_hit_in      = repl_hit_ff;
      repl_idx_in      = repl_idx_ff;
      rsp_valid_in     = 1'b0;
      rsp_word_in      = rsp_word_ff;
      wr_en            = 1'b0;
      wr_idx           = '0;

      if (cmd.load) begin
         req_in       = req_word;
         idx_in       = '0;
         dup_hit_in   = 1'b0;
         free_hit_in  = 1'b0;
         steal_hit_in = 1'b0;
         repl_hit_in  = 1'b0;
      end

      if (cmd.play_step) begin
         if (!dup_hit_ff && cur_pending && cur_active && cur_sound == req_ff.sound_id) begin
            dup_hit_in = 1'b1;
            dup_idx_in = idx_ff;
         end
         if (!free_hit_ff && !cur_pending && !cur_active) begin
            free_hit_in = 1'b1;
            free_idx_in = idx_ff;
         end
         if (!steal_hit_ff && !cur_pending && cur_active &&
             cur_priority <= req_ff.sound_priority) begin
            steal_hit_in = 1'b1;
            steal_idx_in = idx_ff;
         end
         if (!repl_hit_ff && cur_pending && cur_active &&
             cur_priority < req_ff.sound_priority) begin
            repl_hit_in = 1'b1;
            repl_idx_in = idx_ff;
         end
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.play_commit) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in.last      = 1'b1;
         rsp_word_in.action    = pva_pkg::ACT_ASSIGN;
         rsp_word_in.out_sound = req_ff.sound_id;
         priority if (dup_hit_ff) begin
            rsp_word_in.action    = pva_pkg::ACT_REJECT;
            rsp_word_in.out_sound = 8'd0;
            wr_idx                = dup_idx_ff;
         end else if (free_hit_ff) begin
            wr_en  = 1'b1;
            wr_idx = free_idx_ff;
         end else if (steal_hit_ff) begin
            wr_en  = 1'b1;
            wr_idx = steal_idx_ff;
         end else if (repl_hit_ff) begin
            wr_en  = 1'b1;
            wr_idx = repl_idx_ff;
         end else begin
            rsp_word_in.action    = pva_pkg::ACT_DROP;
            rsp_word_in.out_sound = 8'd0;
         end
         rsp_word_in.slot = 2'(wr_idx);
         if (wr_en) begin
            slot_sound_in[wr_idx]    = req_ff.sound_id;
            slot_priority_in[wr_idx] = req_ff.sound_priority;
            slot_hold_in[wr_idx]     = req_ff.hold_units;
            slot_ticks_in[wr_idx]    = 16'd0;
            slot_active_in[wr_idx]   = 1'b1;
            slot_pending_in[wr_idx]  = 1'b1;
         end
      end

      if (cmd.tick_step) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in.slot      = 2'(idx_ff);
         rsp_word_in.last      = last_slot;
         rsp_word_in.action    = pva_pkg::ACT_NO_CHG;
         rsp_word_in.out_sound = 8'd0;
         if (cur_pending) begin
            // pending but inactive never starts
            if (cur_active && !cur_busy) begin
               slot_pending_in[idx_ff] = 1'b0;
               rsp_word_in.action      = pva_pkg::ACT_START;
               rsp_word_in.out_sound   = cur_sound;
            end
         end else if (cur_active) begin
            if (!cur_busy) begin
               slot_active_in[idx_ff] = 1'b0;
               rsp_word_in.action     = pva_pkg::ACT_RELEASE;
            end else if (cur_hold != 8'd0) begin
               if (cur_ticks < hold_limit) begin
                  slot_ticks_in[idx_ff] = cur_ticks + 16'd1;
               end else begin
                  slot_active_in[idx_ff] = 1'b0;
                  rsp_word_in.action     = pva_pkg::ACT_TIMEOUT;
               end
            end
         end
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff  <= '0;
         slot_pending_ff <= '0;
         scale_ff        <= pva_pkg::HOLD_SCALE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         slot_active_ff  <= slot_active_in;
         slot_pending_ff <= slot_pending_in;
         scale_ff        <= scale_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_sound_ff    <= slot_sound_in;
      slot_priority_ff <= slot_priority_in;
      slot_hold_ff     <= slot_hold_in;
      slot_ticks_ff    <= slot_ticks_in;
      req_ff           <= req_in;
      idx_ff           <= idx_in;
      dup_hit_ff       <= dup_hit_in;
      dup_idx_ff       <= dup_idx_in;
      free_hit_ff      <= free_hit_in;
      free_idx_ff      <= free_idx_in;
      steal_hit_ff     <= steal_hit_in;
      steal_idx_ff     <= steal_idx_in;
      repl_hit_ff      <= repl_hit_in;
      repl_idx_ff      <= repl_idx_in;
      rsp_word_ff      <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[tb/sv/priority_voice_allocator_checker.sv]
// result checker for the priority voice allocator: watches request, result and csr ports
// keeps its own slot table, predicts every result word and compares them in order
// depends on pva_pkg

module priority_voice_allocator_checker #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  pva_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  pva_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   output int                    fail_count,
   output int                    outstanding
);

   logic [7:0]   hold_scale;
   logic [7:0]   voice_sound [NUM_SLOTS];
   logic [7:0]   voice_priority [NUM_SLOTS];
   logic [7:0]   voice_hold [NUM_SLOTS];
   logic         voice_active [NUM_SLOTS];
   logic         voice_pending [NUM_SLOTS];
   logic [15:0]  voice_ticks [NUM_SLOTS];
   pva_pkg::rsp_word_type due_results [$];
   pva_pkg::rsp_word_type head_word;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic predict_play(input pva_pkg::req_word_type w);
      int i;
      int found;
      pva_pkg::rsp_word_type r;
      found = -1;
      r.slot = '0;
      r.action = pva_pkg::ACT_DROP;
      r.out_sound = '0;
      r.last = 1'b1;
      for (i = 0; i < NUM_SLOTS; i++)
         if (found < 0 && voice_pending[i] && voice_active[i] && voice_sound[i] == w.sound_id)
            found = i;
      if (found >= 0) begin
         r.slot = 2'(found);
         r.action = pva_pkg::ACT_REJECT;
      end else begin
         // free slot, then steal a playing one, then replace a weaker pending one
         for (i = 0; i < NUM_SLOTS; i++)
            if (found < 0 && !voice_pending[i] && !voice_active[i])
               found = i;
         for (i = 0; i < NUM_SLOTS; i++)
            if (found < 0 && !voice_pending[i] && voice_active[i]
                && voice_priority[i] <= w.sound_priority)
               found = i;
         for (i = 0; i < NUM_SLOTS; i++)
            if (found < 0 && voice_pending[i] && voice_active[i]
                && voice_priority[i] < w.sound_priority)
               found = i;
         if (found >= 0) begin
            voice_sound[found] = w.sound_id;
            voice_priority[found] = w.sound_priority;
            voice_hold[found] = w.hold_units;
            voice_active[found] = 1'b1;
            voice_pending[found] = 1'b1;
            voice_ticks[found] = '0;
            r.slot = 2'(found);
            r.action = pva_pkg::ACT_ASSIGN;
            r.out_sound = w.sound_id;
         end
      end
      due_results.push_back(r);
   endtask

   task automatic predict_tick(input pva_pkg::req_word_type w);
      int i;
      int limit;
      logic idle;
      pva_pkg::rsp_word_type r;
      for (i = 0; i < NUM_SLOTS; i++) begin
         // slots past the mask width have no busy bit and read as idle
         idle = (i < 4) ? !w.channel_busy[i % 4] : 1'b1;
         r.slot = 2'(i);
         r.action = pva_pkg::ACT_NO_CHG;
         r.out_sound = '0;
         r.last = (i == NUM_SLOTS - 1);
         if (voice_pending[i]) begin
            if (voice_active[i] && idle) begin
               voice_pending[i] = 1'b0;
               r.action = pva_pkg::ACT_START;
               r.out_sound = voice_sound[i];
            end
         end else if (voice_active[i]) begin
            if (idle) begin
               voice_active[i] = 1'b0;
               r.action = pva_pkg::ACT_RELEASE;
            end else if (voice_hold[i] != 0) begin
               limit = int'(voice_hold[i]) * int'(hold_scale);
               if (voice_ticks[i] < limit) begin
                  voice_ticks[i] = voice_ticks[i] + 16'd1;
               end else begin
                  voice_active[i] = 1'b0;
                  r.action = pva_pkg::ACT_TIMEOUT;
               end
            end
         end
         due_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hold_scale = pva_pkg::HOLD_SCALE_RESET;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            voice_sound[i] = '0;
            voice_priority[i] = '0;
            voice_hold[i] = '0;
            voice_active[i] = 1'b0;
            voice_pending[i] = 1'b0;
            voice_ticks[i] = '0;
         end
         due_results.delete();
      end else begin
         // results before new words: a word accepted now cannot have a result yet
         if (rsp_valid !== 1'b0) begin
            if (due_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word: slot %0d action %0d sound %0d last %0d",
                           rsp_word.slot, rsp_word.action, rsp_word.out_sound, rsp_word.last);
               fail_count = fail_count + 1;
            end else begin
               head_word = due_results.pop_front();
               if (rsp_word.slot !== head_word.slot || rsp_word.action !== head_word.action
                   || rsp_word.out_sound !== head_word.out_sound
                   || rsp_word.last !== head_word.last) begin
                  if (fail_count < 10)
                     $display(
                        {"result mismatch: expected slot %0d action %0d sound %0d last %0d,",
                         " got slot %0d action %0d sound %0d last %0d"},
                        head_word.slot, head_word.action, head_word.out_sound,
                        head_word.last, rsp_word.slot, rsp_word.action,
                        rsp_word.out_sound, rsp_word.last);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_wr_en)
            hold_scale = csr_wr_data;
         if (start && !busy) begin
            if (req_word.func == pva_pkg::FUNC_PLAY)
               predict_play(req_word);
            else
               predict_tick(req_word);
         end
      end
      outstanding = due_results.size();
   end

endmodule

[tb/sv/priority_voice_allocator_top_test.sv]
// stimulus and verdict for the priority voice allocator
// drives directed and random words under varying sender gaps and hold scales
// depends on pva_pkg, priority_voice_allocator_top, priority_voice_allocator_checker

module priority_voice_allocator_top_test;

   localparam int NUM_SLOTS = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int WORDS_PER_PHASE = 28;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   pva_pkg::req_word_type req_word;
   logic         rsp_valid;
   pva_pkg::rsp_word_type rsp_word;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   int           fail_count;
   int           outstanding;
   int           cycle_count = 0;
   int           sender_idle_pct;

   priority_voice_allocator_top #(
      .NUM_SLOTS(NUM_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   priority_voice_allocator_checker #(
      .NUM_SLOTS(NUM_SLOTS)
   ) voice_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(input pva_pkg::req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_hold_scale(input logic [7:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic pva_pkg::req_word_type play_word(input logic [7:0] id,
                                                       input logic [7:0] pr,
                                                       input logic [7:0] hold);
      pva_pkg::req_word_type w;
      w.func = pva_pkg::FUNC_PLAY;
      w.sound_id = id;
      w.sound_priority = pr;
      w.hold_units = hold;
      w.channel_busy = 4'($urandom);
      return w;
   endfunction

   function automatic pva_pkg::req_word_type tick_word(input logic [3:0] mask);
      pva_pkg::req_word_type w;
      w.func = pva_pkg::FUNC_TICK;
      w.sound_id = 8'($urandom);
      w.sound_priority = 8'($urandom);
      w.hold_units = 8'($urandom);
      w.channel_busy = mask;
      return w;
   endfunction

   function automatic pva_pkg::req_word_type random_word();
      pva_pkg::req_word_type w;
      // a small sound set makes duplicates common, small holds make timeouts reachable
      w.func = ($urandom_range(99) < 55) ? pva_pkg::FUNC_TICK : pva_pkg::FUNC_PLAY;
      w.sound_id = ($urandom_range(99) < 80) ? 8'($urandom_range(7)) : 8'($urandom);
      w.sound_priority = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom);
      w.hold_units = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
      if ($urandom_range(3) == 0)
         w.channel_busy = 4'($urandom);
      else
         w.channel_busy = 4'($urandom) | 4'($urandom) | 4'($urandom);
      return w;
   endfunction

   initial begin
      int idle_of_phase [3];
      logic [7:0] scale_of_phase [3];
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      sender_idle_pct = 0;
      idle_of_phase = '{24, 56, 0};
      scale_of_phase = '{8'd1, 8'd255, 8'($urandom_range(4, 2))};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then allocation, duplicate, drop, replace, steal, release
      send_word(tick_word(4'h0));
      send_word(tick_word(4'hF));
      send_word(play_word(8'd0, 8'd0, 8'd0));
      send_word(play_word(8'd0, 8'd9, 8'd9));
      send_word(play_word(8'd255, 8'd255, 8'd255));
      send_word(play_word(8'd2, 8'd10, 8'd1));
      send_word(play_word(8'd3, 8'd5, 8'd2));
      send_word(play_word(8'd4, 8'd0, 8'd0));
      send_word(play_word(8'd5, 8'd20, 8'd0));
      send_word(tick_word(4'h0));
      send_word(play_word(8'd6, 8'd3, 8'd0));
      send_word(play_word(8'd7, 8'd10, 8'd3));
      send_word(tick_word(4'hF));
      send_word(tick_word(4'b0100));
      send_word(tick_word(4'h0));

      // zero scale: any started busy slot with a hold times out at once
      write_hold_scale(8'd0);
      send_word(play_word(8'd8, 8'd1, 8'd1));
      send_word(tick_word(4'h0));
      send_word(tick_word(4'hF));

      for (int phase = 0; phase < 3; phase++) begin
         write_hold_scale(scale_of_phase[phase]);
         sender_idle_pct = idle_of_phase[phase];
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == WORDS_PER_PHASE / 2)
               drain_results();
            send_word(random_word());
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
design/pva_pkg.sv
design/pva_ctrl.sv
design/pva_datapath.sv
design/priority_voice_allocator_top.sv
tb/sv/priority_voice_allocator_checker.sv
tb/sv/priority_voice_allocator_top_test.sv
